@@ hdl/slkv_pkg.sv @@
// shared types and constants of the segmented lru key/value cache
package slkv_pkg;

  // command codes
  typedef enum logic [1:0] {
    CMD_SET = 2'd0,
    CMD_GET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_NOP = 2'd3
  } slkv_cmd_e;

  localparam int unsigned KEY_W         = 64;
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // key modulo segment count is reduced this many key bits per cycle
  localparam int unsigned KEY_STEP_BITS = 8;
  localparam int unsigned MOD_STEPS     = KEY_W / KEY_STEP_BITS;

  typedef struct packed {
    logic [1:0]        command;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } slkv_req_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
  } slkv_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear_wr;
    logic mod_step;
    logic scan_rd;
    logic upd_rd;
    logic step_clr;
    logic respond;
  } slkv_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic mod_done;
    logic pass_done;
    logic is_nop;
    logic needs_update;
  } slkv_sts_t;

endpackage

@@ hdl/slkv_datapath.sv @@
// datapath: key reduction, entry memory, scan accumulators and update logic
module slkv_datapath #(
  parameter int unsigned SEGMENTS   = 4,
  parameter int unsigned WAYS       = 16,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slkv_pkg::slkv_ctl_t          ctl_i,
  output slkv_pkg::slkv_sts_t          sts_o,
  input  slkv_pkg::slkv_req_t          req_i,
  input  logic                         cfg_we_i,
  input  logic [slkv_pkg::CAP_W-1:0]   cfg_wdata_i,
  output logic                         rsp_valid_o,
  output slkv_pkg::slkv_rsp_t          rsp_o
);
  import slkv_pkg::*;

  localparam int unsigned SLOTS  = SEGMENTS * WAYS;
  localparam int unsigned AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned RANK_W = WAY_W;
  localparam int unsigned SEG_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned CNT_W  = $clog2(WAYS + 1);
  localparam int unsigned STEP_W = $clog2(SLOTS + WAYS + MOD_STEPS);

  typedef struct packed {
    logic                  valid;
    logic [KEY_W-1:0]      key;
    logic [VALUE_BITS-1:0] value;
    logic [RANK_W-1:0]     rank;
  } entry_t;

  entry_t mem [SLOTS];

  slkv_cmd_e             cmd_q;
  logic [KEY_W-1:0]      key_q;
  logic [KEY_W-1:0]      key_sh_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [SEG_W-1:0]      rem_q;
  logic [SEG_W-1:0]      rem_d;
  logic [SEG_W:0]        rem_ext;
  logic [STEP_W-1:0]     step_q;
  logic [CAP_W-1:0]      cap_q;
  logic [CNT_W-1:0]      eff_cap;

  logic                  rd_en;
  logic [AW-1:0]         base;
  logic [AW-1:0]         rd_addr;
  logic                  rd_vld_q;
  logic                  rd_upd_q;
  logic [WAY_W-1:0]      rd_way_q;
  entry_t                rd_data_q;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  entry_t                wr_data;
  entry_t                upd_entry;

  logic                  hit_q;
  logic [WAY_W-1:0]      hit_way_q;
  logic [RANK_W-1:0]     hit_rank_q;
  logic [VALUE_BITS-1:0] hit_value_q;
  logic [CNT_W-1:0]      count_q;
  logic                  free_found_q;
  logic [WAY_W-1:0]      free_way_q;
  logic                  vic_found_q;
  logic [WAY_W-1:0]      vic_way_q;
  logic [RANK_W-1:0]     vic_rank_q;

  logic                  scan_vld;
  logic                  scan_hit;
  logic                  evict;
  logic [WAY_W-1:0]      ins_way;
  logic                  rsp_vld_q;
  slkv_rsp_t             rsp_q;

  // segment base from the remainder
  assign base    = AW'(32'(rem_q) * WAYS);
  assign rd_en   = (ctl_i.scan_rd || ctl_i.upd_rd) && (step_q < STEP_W'(WAYS));
  assign rd_addr = base + AW'(step_q[WAY_W-1:0]);

  // eight restoring steps of key modulo segment count, msb first
  always_comb begin
    rem_d   = rem_q;
    rem_ext = '0;
    for (int i = 0; i < KEY_STEP_BITS; i++) begin
      rem_ext = {rem_d, key_sh_q[KEY_W-1-i]};
      if (rem_ext >= (SEG_W+1)'(SEGMENTS)) begin
        rem_ext = rem_ext - (SEG_W+1)'(SEGMENTS);
      end
      rem_d = rem_ext[SEG_W-1:0];
    end
  end

  // capacity clamped to 1..WAYS
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_q) > WAYS) begin
      eff_cap = CNT_W'(WAYS);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      cap_q     <= CAP_RESET;
      rd_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
    end else begin
      step_q    <= ctl_i.step_clr ? '0 : step_q + STEP_W'(1);
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      rd_vld_q  <= rd_en;
      rsp_vld_q <= ctl_i.respond;
    end
  end

  // request capture and key reduction
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q    <= slkv_cmd_e'(req_i.command);
      key_q    <= req_i.key;
      key_sh_q <= req_i.key;
      val_q    <= req_i.value[VALUE_BITS-1:0];
      rem_q    <= '0;
    end else if (ctl_i.mod_step) begin
      key_sh_q <= key_sh_q << KEY_STEP_BITS;
      rem_q    <= rem_d;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    rd_upd_q <= ctl_i.upd_rd;
    rd_way_q <= step_q[WAY_W-1:0];
  end

  assign scan_vld = rd_vld_q && !rd_upd_q;
  assign scan_hit = scan_vld && rd_data_q.valid && (rd_data_q.key == key_q);

  // scan accumulators
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      hit_q        <= 1'b0;
      count_q      <= '0;
      free_found_q <= 1'b0;
      vic_found_q  <= 1'b0;
    end else if (scan_vld) begin
      if (rd_data_q.valid) begin
        count_q <= count_q + CNT_W'(1);
        if (!hit_q && scan_hit) begin
          hit_q       <= 1'b1;
          hit_way_q   <= rd_way_q;
          hit_rank_q  <= rd_data_q.rank;
          hit_value_q <= rd_data_q.value;
        end
        if (!vic_found_q || (rd_data_q.rank > vic_rank_q)) begin
          vic_found_q <= 1'b1;
          vic_way_q   <= rd_way_q;
          vic_rank_q  <= rd_data_q.rank;
        end
      end else if (!free_found_q) begin
        free_found_q <= 1'b1;
        free_way_q   <= rd_way_q;
      end
    end
  end

  // set miss on a full segment evicts the least recent entry
  assign evict   = (cmd_q == CMD_SET) && !hit_q && (count_q >= eff_cap);
  assign ins_way = (evict && !(free_found_q && (free_way_q < vic_way_q))) ? vic_way_q
                                                                            : free_way_q;

  // new contents of one way during the update pass
  always_comb begin
    upd_entry = rd_data_q;
    if (hit_q) begin
      if (cmd_q == CMD_DEL) begin
        if (rd_way_q == hit_way_q) begin
          upd_entry.valid = 1'b0;
        end else if (rd_data_q.valid && (rd_data_q.rank > hit_rank_q)) begin
          upd_entry.rank = rd_data_q.rank - RANK_W'(1);
        end
      end else begin
        if (rd_way_q == hit_way_q) begin
          upd_entry.rank = '0;
          if (cmd_q == CMD_SET) begin
            upd_entry.value = val_q;
          end
        end else if (rd_data_q.valid && (rd_data_q.rank < hit_rank_q)) begin
          upd_entry.rank = rd_data_q.rank + RANK_W'(1);
        end
      end
    end else if (cmd_q == CMD_SET) begin
      if (rd_way_q == ins_way) begin
        upd_entry.valid = 1'b1;
        upd_entry.key   = key_q;
        upd_entry.value = val_q;
        upd_entry.rank  = '0;
      end else if (evict && (rd_way_q == vic_way_q)) begin
        // victim freed while the new key lands in a lower free way
        upd_entry.valid = 1'b0;
      end else if (rd_data_q.valid) begin
        if (evict && (rd_data_q.rank > vic_rank_q)) begin
          upd_entry.rank = rd_data_q.rank;
        end else begin
          upd_entry.rank = rd_data_q.rank + RANK_W'(1);
        end
      end
    end
  end

  always_comb begin
    wr_en   = ctl_i.clear_wr || (rd_vld_q && rd_upd_q);
    wr_addr = base + AW'(rd_way_q);
    wr_data = upd_entry;
    if (ctl_i.clear_wr) begin
      wr_addr = step_q[AW-1:0];
      wr_data = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.respond) begin
      rsp_q.found      <= hit_q;
      rsp_q.read_value <= ((cmd_q == CMD_GET) && hit_q) ? DATA_W'(hit_value_q) : '0;
    end
  end

  assign sts_o.clear_done   = (step_q == STEP_W'(SLOTS - 1));
  assign sts_o.mod_done     = (step_q == STEP_W'(MOD_STEPS - 1));
  assign sts_o.pass_done    = (step_q == STEP_W'(WAYS));
  assign sts_o.is_nop       = (cmd_q == CMD_NOP);
  assign sts_o.needs_update = (cmd_q == CMD_SET) || hit_q || scan_hit;

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

endmodule

@@ hdl/slkv_ctrl.sv @@
// controller: sequences clear, key reduction, scan, update and response
module slkv_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  slkv_pkg::slkv_sts_t sts_i,
  output slkv_pkg::slkv_ctl_t ctl_o,
  output logic                busy_o
);
  import slkv_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_SCAN,
    S_UPDATE,
    S_RESP
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   busy_q;

  always_comb begin
    ctl_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        ctl_o.clear_wr = 1'b1;
        if (sts_i.clear_done) begin
          ctl_o.step_clr = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load     = 1'b1;
          ctl_o.step_clr = 1'b1;
          state_d        = S_MOD;
        end
      end
      S_MOD: begin
        if (sts_i.is_nop) begin
          state_d = S_RESP;
        end else begin
          ctl_o.mod_step = 1'b1;
          if (sts_i.mod_done) begin
            ctl_o.step_clr = 1'b1;
            state_d        = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl_o.scan_rd = 1'b1;
        if (sts_i.pass_done) begin
          ctl_o.step_clr = 1'b1;
          state_d        = sts_i.needs_update ? S_UPDATE : S_RESP;
        end
      end
      S_UPDATE: begin
        ctl_o.upd_rd = 1'b1;
        if (sts_i.pass_done) begin
          ctl_o.step_clr = 1'b1;
          state_d        = S_RESP;
        end
      end
      S_RESP: begin
        ctl_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

@@ hdl/segmented_lru_key_value_cache.sv @@
// top level of the segmented lru key/value cache
// set commands and get or delete hits run an update pass after the scan pass; get or delete
//   misses respond after the scan pass, and the unused command code skips reduction and scan
// one command at a time; the next start is taken in the cycle the result strobe is high
// the time a command takes is set by the key-modulo reduction (8 key bits a cycle) and by the
//   passes over the segment's ways through the single read port of the entry memory
// after reset a clearing pass writes every slot of the entry memory with busy high; results
//   cannot be stalled by the receiver
module segmented_lru_key_value_cache #(
  parameter int unsigned SEGMENTS   = 4,
  parameter int unsigned WAYS       = 16,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command transfer: taken when start is high and busy is low
  input  logic                       start_i,
  output logic                       busy_o,
  input  slkv_pkg::slkv_req_t        req_i,
  // result transfer: one cycle strobe, no back pressure
  output logic                       rsp_valid_o,
  output slkv_pkg::slkv_rsp_t        rsp_o,
  // segment capacity register
  input  logic                       cfg_we_i,
  input  logic [slkv_pkg::CAP_W-1:0] cfg_wdata_i
);
  import slkv_pkg::*;

  slkv_ctl_t ctl;
  slkv_sts_t sts;

  // sequencer: clear sweep, then per command mod, scan, optional update, respond; nop skips mod and scan
  slkv_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy_o)
  );

  // entry memory holds valid, key, value and recency rank per slot;
  // the scan pass finds hit, fill, first free way and eviction victim,
  // the update pass rewrites every way of the segment once
  slkv_datapath #(
    .SEGMENTS   (SEGMENTS),
    .WAYS       (WAYS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule
